/* hdl/sha_pkg.sv */
// Shared types, constants and functions of the SHA-256 hash engine.
`default_nettype none

package sha_pkg;

    // Number of compression rounds per block
    localparam int unsigned Rounds = 64;

    // One message word as it arrives on the input channel
    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        final_item;
    } msg_word_t;

    // One digest word as it leaves on the output channel
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_word_t;

    // Source of a word pushed into the schedule window
    localparam logic [2:0] PUSH_INPUT  = 3'd0;
    localparam logic [2:0] PUSH_MARK   = 3'd1;
    localparam logic [2:0] PUSH_ZERO   = 3'd2;
    localparam logic [2:0] PUSH_LEN_HI = 3'd3;
    localparam logic [2:0] PUSH_LEN_LO = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       push;
        logic [2:0] push_sel;
        logic       load_vars;
        logic       round_en;
        logic [5:0] round_idx;
        logic       add_chain;
        logic       load_digest;
        logic       restart;
        logic       len_add;
        logic       out_shift;
    } sha_cmd_t;

    // Initial hash value, word by word
    function automatic logic [31:0] start_chain_word(input logic [2:0] idx);
        logic [31:0] h;
        unique case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    // Round constants
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

/* hdl/sha_datapath.sv */
// Datapath of the SHA-256 hash engine: window, round variables, chain, length, digest.
`default_nettype none

module sha_datapath
    import sha_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire sha_cmd_t  cmd,
    input  wire msg_word_t msg,
    output logic [31:0]    digest_word
);

    logic [31:0] window_reg [16];
    logic [31:0] vars_reg   [8];
    logic [31:0] chain_reg  [8];
    logic [31:0] digest_reg [8];
    logic [63:0] len_reg;

    logic [2:0]  nbytes;
    logic [31:0] in_word;
    logic [31:0] push_word;
    logic [31:0] sched_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [63:0] len_inc;

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Byte count of a final word, oversized counts taken as a full word
    assign nbytes = msg.valid_bytes[2] ? 3'd4 : msg.valid_bytes;

    // Final word with its unused bytes dropped and, when it holds fewer than four bytes, the 0x80 marker appended
    always_comb
    begin
        if (!msg.final_item)
        begin
            in_word = msg.message_word;
        end
        else
        begin
            unique case (nbytes)
                3'd0:    in_word = 32'h8000_0000;
                3'd1:    in_word = {msg.message_word[31:24], 24'h80_0000};
                3'd2:    in_word = {msg.message_word[31:16], 16'h8000};
                3'd3:    in_word = {msg.message_word[31:8], 8'h80};
                default: in_word = msg.message_word;
            endcase
        end
    end

    // Word to append to the schedule window
    always_comb
    begin
        unique case (cmd.push_sel)
            PUSH_INPUT:  push_word = in_word;
            PUSH_MARK:   push_word = 32'h8000_0000;
            PUSH_LEN_HI: push_word = len_reg[63:32];
            PUSH_LEN_LO: push_word = len_reg[31:0];
            default:     push_word = '0;
        endcase
    end

    // Message length increment in bits
    assign len_inc = msg.final_item ? {58'd0, nbytes, 3'b000} : 64'd32;

    // Next schedule word; the window always holds W(t) .. W(t+15)
    assign sched_new = (ror(window_reg[14], 17) ^ ror(window_reg[14], 19)
                        ^ (window_reg[14] >> 10))
                     + window_reg[9]
                     + (ror(window_reg[1], 7) ^ ror(window_reg[1], 18)
                        ^ (window_reg[1] >> 3))
                     + window_reg[0];

    // Round function
    assign t1 = vars_reg[7]
              + (ror(vars_reg[4], 6) ^ ror(vars_reg[4], 11) ^ ror(vars_reg[4], 25))
              + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
              + round_k(cmd.round_idx) + window_reg[0];
    assign t2 = (ror(vars_reg[0], 2) ^ ror(vars_reg[0], 13) ^ ror(vars_reg[0], 22))
              + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                 ^ (vars_reg[1] & vars_reg[2]));

    // Schedule window: shifts on every push and every round
    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                window_reg[i] <= window_reg[i + 1];
            end
            window_reg[15] <= cmd.push ? push_word : sched_new;
        end
    end

    // Round variables a to h
    always_ff @(posedge clk)
    begin
        if (cmd.load_vars)
        begin
            for (int i = 0; i < 8; i++)
            begin
                vars_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            vars_reg[7] <= vars_reg[6];
            vars_reg[6] <= vars_reg[5];
            vars_reg[5] <= vars_reg[4];
            vars_reg[4] <= vars_reg[3] + t1;
            vars_reg[3] <= vars_reg[2];
            vars_reg[2] <= vars_reg[1];
            vars_reg[1] <= vars_reg[0];
            vars_reg[0] <= t1 + t2;
        end
    end

    // Chain value and message length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= start_chain_word(3'(i));
            end
            len_reg <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= start_chain_word(3'(i));
                end
                len_reg <= '0;
            end
            else
            begin
                if (cmd.add_chain)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + vars_reg[i];
                    end
                end
                if (cmd.len_add)
                begin
                    len_reg <= len_reg + len_inc;
                end
            end
        end
    end

    // Digest output register, shifted out one word at a time
    always_ff @(posedge clk)
    begin
        if (cmd.load_digest)
        begin
            for (int i = 0; i < 8; i++)
            begin
                digest_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.out_shift)
        begin
            for (int i = 0; i < 7; i++)
            begin
                digest_reg[i] <= digest_reg[i + 1];
            end
            digest_reg[7] <= digest_reg[7];
        end
    end

    assign digest_word = digest_reg[0];

endmodule

`default_nettype wire

/* hdl/sha_ctrl.sv */
// Controller of the SHA-256 hash engine: input handshake, padding, rounds and output.
`default_nettype none

module sha_ctrl
    import sha_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       msg_valid,
    output logic            msg_ready,
    input  wire logic [2:0] valid_bytes,
    input  wire logic       final_item,
    output logic            digest_valid,
    input  wire logic       digest_ready,
    output logic [2:0]      word_index,
    output logic            last_word,
    output sha_cmd_t        cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // Padding progress of the current message
    localparam logic [2:0] PH_NONE  = 3'd0;
    localparam logic [2:0] PH_MARK  = 3'd1;
    localparam logic [2:0] PH_ZERO  = 3'd2;
    localparam logic [2:0] PH_LENLO = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    localparam logic [5:0] LastRound = 6'(Rounds - 1);

    logic [2:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [3:0] count_reg, count_next;
    logic [5:0] round_reg, round_next;
    logic       out_busy_reg, out_busy_next;
    logic [2:0] out_idx_reg, out_idx_next;
    logic       accept;
    logic       out_take;

    assign msg_ready    = (state_reg == S_IDLE);
    assign accept       = msg_valid && msg_ready;
    assign digest_valid = out_busy_reg;
    assign out_take     = digest_valid && digest_ready;
    assign word_index   = out_idx_reg;
    assign last_word    = (out_idx_reg == 3'd7);

    // Sequencing of words, padding and rounds
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        round_next = round_reg;

        cmd           = '0;
        cmd.push_sel  = PUSH_INPUT;
        cmd.round_idx = round_reg;
        cmd.out_shift = out_take;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.push    = 1'b1;
                    cmd.len_add = 1'b1;
                    if (final_item)
                    begin
                        phase_next = valid_bytes[2] ? PH_MARK : PH_ZERO;
                    end
                    if (count_reg == 4'd15)
                    begin
                        cmd.load_vars = 1'b1;
                        state_next    = S_ROUND;
                    end
                    else if (final_item)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                cmd.push = 1'b1;
                priority if (phase_reg == PH_MARK)
                begin
                    cmd.push_sel = PUSH_MARK;
                    phase_next   = PH_ZERO;
                end
                else if (phase_reg == PH_ZERO)
                begin
                    if (count_reg == 4'd14)
                    begin
                        cmd.push_sel = PUSH_LEN_HI;
                        phase_next   = PH_LENLO;
                    end
                    else
                    begin
                        cmd.push_sel = PUSH_ZERO;
                    end
                end
                else
                begin
                    cmd.push_sel = PUSH_LEN_LO;
                    phase_next   = PH_DONE;
                end
                if (count_reg == 4'd15)
                begin
                    cmd.load_vars = 1'b1;
                    state_next    = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (round_reg == LastRound)
                begin
                    round_next = '0;
                    state_next = S_ADD;
                end
                else
                begin
                    round_next = round_reg + 6'd1;
                end
            end
            S_ADD:
            begin
                cmd.add_chain = 1'b1;
                priority if (phase_reg == PH_NONE)
                begin
                    state_next = S_IDLE;
                end
                else if (phase_reg == PH_DONE)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_PAD;
                end
            end
            S_FIN:
            begin
                if (!out_busy_reg)
                begin
                    cmd.load_digest = 1'b1;
                    cmd.restart     = 1'b1;
                    phase_next      = PH_NONE;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign count_next = cmd.push ? count_reg + 4'd1 : count_reg;

    // Output word counter
    always_comb
    begin
        out_busy_next = out_busy_reg;
        out_idx_next  = out_idx_reg;
        if (cmd.load_digest)
        begin
            out_busy_next = 1'b1;
            out_idx_next  = '0;
        end
        else if (out_take)
        begin
            out_idx_next = out_idx_reg + 3'd1;
            if (out_idx_reg == 3'd7)
            begin
                out_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_NONE;
            count_reg    <= '0;
            round_reg    <= '0;
            out_busy_reg <= 1'b0;
            out_idx_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            round_reg    <= round_next;
            out_busy_reg <= out_busy_next;
            out_idx_reg  <= out_idx_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/sha256_hash_engine.sv */
// Top level of the SHA-256 hash engine.
//
// Takes a message as big-endian 32-bit words, each carrying up to four bytes,
// the final word flagged, and returns the eight words of its SHA-256 digest,
// most significant first, after which it starts afresh from the initial hash.
// A block takes in its sixteen accepted words, then runs its 64 rounds (one
// round per cycle in a single round unit) and folds the result into the
// chain value; no words are taken while the rounds and the fold run.
// The final word adds the padding words, one or two more compressions, and
// a move of the digest into the output register once the previous digest
// has left; the digest words then leave at one per cycle while the receiver
// is ready, while the next message is already being taken in.
`default_nettype none

module sha256_hash_engine
    import sha_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         msg_valid,
    output logic              msg_ready,
    input  wire msg_word_t    msg,
    output logic              digest_valid,
    input  wire logic         digest_ready,
    output digest_word_t      digest
);

    sha_cmd_t    cmd;
    logic [31:0] dp_word;
    logic [2:0]  out_index;
    logic        out_last;

    // Controller
    sha_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .valid_bytes  (msg.valid_bytes),
        .final_item   (msg.final_item),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .word_index   (out_index),
        .last_word    (out_last),
        .cmd          (cmd)
    );

    // Datapath
    sha_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .msg         (msg),
        .digest_word (dp_word)
    );

    assign digest.digest_word = dp_word;
    assign digest.word_index  = out_index;
    assign digest.last_word   = out_last;

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the SHA-256 hash engine, with its own digest predictor.
`timescale 1ns / 100ps

module tb
    import sha_pkg::*;
();

    // Initial hash value and round constants of FIPS 180-4
    localparam logic [31:0] IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam int RANDOM_WORDS = 90;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         msg_valid    = 1'b0;
    msg_word_t    msg          = '0;
    logic         digest_ready = 1'b0;
    logic         msg_ready;
    logic         digest_valid;
    digest_word_t digest;

    // Predictor state: chain value, schedule buffer and running length
    logic [31:0]  chain_state [8];
    logic [31:0]  schedule_buf [16];
    logic [3:0]   buf_fill;
    logic [63:0]  msg_bits;
    digest_word_t expected_digest [$];

    int mismatch_count = 0;
    int words_sent     = 0;
    int burst_left     = 0;

    sha256_hash_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Expand the sixteen buffered words and fold 64 rounds into the chain value.
    function automatic void compress_schedule();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 16; t++)
            w[t] = schedule_buf[t];
        for (int t = 16; t < 64; t++)
        begin
            s0   = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1   = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int i = 0; i < 8; i++)
            v[i] = chain_state[i];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_state[i] = chain_state[i] + v[i];
    endfunction

    function automatic void buffer_word(input logic [31:0] w);
        schedule_buf[buf_fill] = w;
        buf_fill = buf_fill + 4'd1;
        if (buf_fill == 4'd0)
            compress_schedule();
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
            chain_state[i] = IV_WORDS[i];
        buf_fill = 4'd0;
        msg_bits = 64'd0;
    endfunction

    // Update the predictor with one accepted word; a final word queues the digest.
    function automatic void predict_digest(input msg_word_t m);
        logic [2:0]   nbytes;
        logic [31:0]  keep;
        digest_word_t d;
        if (!m.final_item)
        begin
            // Byte count is ignored on a word that is not final.
            msg_bits = msg_bits + 64'd32;
            buffer_word(m.message_word);
        end
        else
        begin
            // Counts above four act as four.
            nbytes   = (m.valid_bytes > 3'd4) ? 3'd4 : m.valid_bytes;
            msg_bits = msg_bits + 64'(nbytes) * 64'd8;
            if (nbytes == 3'd4)
            begin
                buffer_word(m.message_word);
                buffer_word(32'h8000_0000);
            end
            else
            begin
                keep = (nbytes == 3'd0) ? 32'd0 : (32'hffff_ffff << (32 - 8 * nbytes));
                buffer_word((m.message_word & keep) | (32'h8000_0000 >> (8 * nbytes)));
            end
            while (buf_fill != 4'd14)
                buffer_word(32'd0);
            buffer_word(msg_bits[63:32]);
            buffer_word(msg_bits[31:0]);
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = chain_state[i];
                d.word_index  = 3'(i);
                d.last_word   = (i == 7);
                expected_digest.push_back(d);
            end
            restart_hash();
        end
    endfunction

    // Send one word, opening a new burst after a random gap when the last one ran out.
    task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                             input logic last);
        msg_word_t m;
        int        gap;
        m.message_word = data;
        m.valid_bytes  = nbytes;
        m.final_item   = last;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                msg_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        msg_valid <= 1'b1;
        msg       <= m;
        do
            @(posedge clk);
        while (!msg_ready);
        predict_digest(m);
        burst_left--;
        words_sent++;
    endtask

    task automatic send_message(input int nwords, input logic [2:0] final_bytes);
        logic [2:0] nb;
        for (int i = 0; i < nwords; i++)
        begin
            // Mostly full words, now and then a stray byte count.
            nb = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            send_word($urandom, nb, 1'b0);
        end
        send_word($urandom, final_bytes, 1'b1);
    endtask

    // Empty message; the bytes of the final word must all be ignored.
    task automatic test_empty_message();
        send_word(32'hdead_beef, 3'd0, 1'b1);
    endtask

    // One-word messages of one to four bytes, most at the data extremes.
    task automatic test_short_finals();
        send_word(32'hffff_ffff, 3'd1, 1'b1);
        send_word(32'h0000_0000, 3'd2, 1'b1);
        send_word(32'h6162_6300, 3'd3, 1'b1);
        send_word(32'hffff_ffff, 3'd4, 1'b1);
    endtask

    // Byte counts above four on a final word.
    task automatic test_oversized_counts();
        send_word(32'h0123_4567, 3'd5, 1'b1);
        send_word(32'hfedc_ba98, 3'd7, 1'b1);
    endtask

    // Stray byte counts on words that are not final count as four bytes.
    task automatic test_partial_middle_words();
        send_word(32'hffff_ffff, 3'd0, 1'b0);
        send_word(32'ha5a5_5a5a, 3'd3, 1'b0);
        send_word(32'h0000_0000, 3'd6, 1'b0);
        send_word(32'hcafe_f00d, 3'd2, 1'b1);
    endtask

    // Thirteen words and a full final word: the padding spills into a second block.
    task automatic test_two_block_padding();
        for (int i = 0; i < 13; i++)
            send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd4, 1'b1);
    endtask

    // Random messages: half short, the rest mostly near a block boundary.
    task automatic test_random_messages();
        int start;
        int nwords;
        int pick;
        logic [2:0] fb;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                nwords = $urandom_range(0, 4);
            else if (pick < 8)
                nwords = $urandom_range(12, 16);
            else
                nwords = $urandom_range(17, 33);
            fb = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            send_message(nwords, fb);
        end
    endtask

    // Receiver stall pattern, in one of four modes drawn at random.
    int stall_tick = 0;
    int stall_mode = 0;
    always @(posedge clk)
    begin
        if (stall_tick % 48 == 0)
            stall_mode = $urandom_range(0, 3);
        stall_tick++;
        case (stall_mode)
            0: digest_ready <= 1'b1;
            1: digest_ready <= $urandom_range(0, 1);
            2: digest_ready <= (stall_tick % 4 == 0);
            default: digest_ready <= (stall_tick % 16 == 0);
        endcase
    end

    task automatic flag_mismatch(input string text);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, text);
    endtask

    // Compare each accepted digest word with the oldest expectation.
    always @(posedge clk)
    begin : check_digest
        digest_word_t want;
        if (rst_n && digest_valid && digest_ready)
        begin
            if (expected_digest.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected digest word %h index %0d last %0b",
                                        digest.digest_word, digest.word_index,
                                        digest.last_word));
            end
            else
            begin
                want = expected_digest.pop_front();
                if (digest.digest_word !== want.digest_word)
                    flag_mismatch($sformatf("digest_word: expected %h, got %h",
                                            want.digest_word, digest.digest_word));
                if (digest.word_index !== want.word_index)
                    flag_mismatch($sformatf("word_index: expected %0d, got %0d",
                                            want.word_index, digest.word_index));
                if (digest.last_word !== want.last_word)
                    flag_mismatch($sformatf("last_word: expected %0b, got %0b",
                                            want.last_word, digest.last_word));
            end
        end
    end

    // Main sequence.
    initial
    begin
        restart_hash();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_message();
        test_short_finals();
        test_oversized_counts();
        test_partial_middle_words();
        test_two_block_padding();
        test_random_messages();
        msg_valid <= 1'b0;
        while (expected_digest.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sha256_hash_engine.f */
hdl/sha_pkg.sv
hdl/sha_datapath.sv
hdl/sha_ctrl.sv
hdl/sha256_hash_engine.sv
tb/tb.sv
